/* hw/rtl/nvcls_pkg.sv */
// Shared types for the counter log store: opcodes, controller states and
// the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package nvcls_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned REC_W  = 128;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned RAW_SLOT_W = 8;
  localparam logic [CFG_W-1:0] RECORDS_RESET = 9'd128;

  typedef enum logic [1:0] {
    OP_SCAN    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ERASE   = 2'd2,
    OP_PRELOAD = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK_FULL,
    ST_SWEEP,
    ST_PROG_RD,
    ST_PROG_WR,
    ST_PRELOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic scan_start;
    logic scan_step;
    logic sweep_step;
    logic erase_done;
    logic prog_rd;
    logic prog_wr;
    logic preload_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic known;
    logic slot_full;
    logic scan_done;
    logic sweep_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/nvcls_ctrl.sv */
// Controller state machine of the counter log store.
// Depends on nvcls_pkg; drives the command bundle of nvcls_dpath.
`default_nettype none

module nvcls_ctrl
  import nvcls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  op_t    in_op_dec;

  assign in_op_dec = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= OP_SCAN;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // Power-on pass that sets every record to the erased pattern.
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          op_nxt       = in_op_dec;
          unique case (in_op_dec)
            OP_SCAN: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            OP_WRITE: begin
              if (sts.known) begin
                state_nxt = ST_CHECK_FULL;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
            OP_ERASE:   state_nxt = ST_SWEEP;
            OP_PRELOAD: state_nxt = ST_PRELOAD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (op_r == OP_WRITE) ? ST_CHECK_FULL : ST_DONE;
        end
      end
      ST_CHECK_FULL: begin
        state_nxt = sts.slot_full ? ST_SWEEP : ST_PROG_RD;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.erase_done = 1'b1;
          state_nxt      = (op_r == OP_WRITE) ? ST_PROG_RD : ST_DONE;
        end
      end
      ST_PROG_RD: begin
        cmd.prog_rd = 1'b1;
        state_nxt   = ST_PROG_WR;
      end
      ST_PROG_WR: begin
        cmd.prog_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_PRELOAD: begin
        cmd.preload_wr = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/nvcls_dpath.sv */
// Datapath of the counter log store: record memory, scan pipeline, free
// slot tracking and the result register. Depends on nvcls_pkg.
`default_nettype none

module nvcls_dpath
  import nvcls_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic [HALF_W-1:0]     in_reset_count_in,
  input  wire logic [HALF_W-1:0]     in_power_count_in,
  input  wire logic [RAW_SLOT_W-1:0] in_raw_slot,
  input  wire logic [WORD_W-1:0]     in_raw_value,
  input  wire logic [WORD_W-1:0]     in_raw_check,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_found_valid,
  output logic [HALF_W-1:0]          out_reset_count_out,
  output logic [HALF_W-1:0]          out_power_count_out,
  output logic [CFG_W-1:0]           out_next_slot,
  output logic                       out_page_erased
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_RECORDS - 1);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_RECORDS);

  // Each entry holds the value in the upper half and its check below it.
  logic [REC_W-1:0] mem [MAX_RECORDS];
  logic [REC_W-1:0] rd_data_r;

  logic [CFG_W-1:0]      records_r;
  logic [CW-1:0]         free_r;
  logic                  known_r;
  logic [AW-1:0]         sweep_idx_r;
  logic [CW-1:0]         idx_r;
  logic [CW-1:0]         rd_idx_r;
  logic                  rd_vld_r;
  logic                  found_r;
  logic [WORD_W-1:0]     last_r;
  logic                  erased_r;
  logic [WORD_W-1:0]     data_r;
  logic [RAW_SLOT_W-1:0] raw_slot_r;
  logic [WORD_W-1:0]     raw_value_r;
  logic [WORD_W-1:0]     raw_check_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [WORD_W-1:0]     out_last_r;
  logic [CFG_W-1:0]      out_next_r;
  logic                  out_erased_r;

  logic [CW-1:0]     slot_cnt;
  logic              issue_more;
  logic [WORD_W-1:0] rd_value;
  logic [WORD_W-1:0] rd_check;
  logic              rd_erased;
  logic              rd_good;
  logic              scan_done;
  logic              raw_in_range;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [REC_W-1:0]  wr_data;

  // Slot count in use, with zero taken as one and large values clamped.
  always_comb begin
    if (records_r == '0) begin
      slot_cnt = CW'(1);
    end else if (32'(records_r) > MAX_RECORDS) begin
      slot_cnt = MAX_CNT;
    end else begin
      slot_cnt = CW'(records_r);
    end
  end

  assign issue_more   = idx_r < slot_cnt;
  assign rd_value     = rd_data_r[REC_W-1:WORD_W];
  assign rd_check     = rd_data_r[WORD_W-1:0];
  assign rd_erased    = (&rd_value) && (&rd_check);
  assign rd_good      = rd_check == ~rd_value;
  // The scan ends at the first erased record, or once every slot is read.
  assign scan_done    = (rd_vld_r && rd_erased) || (!rd_vld_r && !issue_more);
  assign raw_in_range = 32'(raw_slot_r) < MAX_RECORDS;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(idx_r);
    if (cmd.scan_step && issue_more) begin
      rd_en = 1'b1;
    end else if (cmd.prog_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(free_r);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_idx_r;
    wr_data = '1;
    if (cmd.sweep_step) begin
      wr_en = 1'b1;
    end else if (cmd.prog_wr) begin
      // Programming only clears bits of what is already stored.
      wr_en   = 1'b1;
      wr_addr = AW'(free_r);
      wr_data = {rd_value & data_r, rd_check & ~data_r};
    end else if (cmd.preload_wr && raw_in_range) begin
      wr_en   = 1'b1;
      wr_addr = AW'(raw_slot_r);
      wr_data = {raw_value_r, raw_check_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Item payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      data_r      <= {in_power_count_in, in_reset_count_in};
      raw_slot_r  <= in_raw_slot;
      raw_value_r <= in_raw_value;
      raw_check_r <= in_raw_check;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step && issue_more) begin
      idx_r    <= idx_r + 1'b1;
      rd_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      records_r   <= RECORDS_RESET;
      free_r      <= '0;
      known_r     <= 1'b0;
      sweep_idx_r <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      last_r      <= '0;
      erased_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        records_r <= cfg_wr_data;
        known_r   <= 1'b0;
      end
      if (cmd.latch_in) begin
        found_r  <= 1'b0;
        last_r   <= '0;
        erased_r <= 1'b0;
      end
      if (cmd.scan_start) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld_r <= issue_more;
        if (rd_vld_r && !rd_erased && rd_good) begin
          found_r <= 1'b1;
          last_r  <= rd_value;
        end
        if (scan_done) begin
          free_r  <= rd_vld_r ? rd_idx_r : slot_cnt;
          known_r <= 1'b1;
        end
      end
      if (cmd.sweep_step) begin
        sweep_idx_r <= (sweep_idx_r == LAST_ADDR) ? '0 : sweep_idx_r + 1'b1;
      end
      if (cmd.erase_done) begin
        free_r   <= '0;
        known_r  <= 1'b1;
        erased_r <= 1'b1;
      end
      if (cmd.prog_wr) begin
        free_r  <= free_r + 1'b1;
        found_r <= 1'b1;
        last_r  <= data_r;
      end
      if (cmd.preload_wr && raw_in_range) begin
        known_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r  <= found_r;
      out_last_r   <= last_r;
      out_next_r   <= CFG_W'(free_r);
      out_erased_r <= erased_r;
    end
  end

  assign sts.known      = known_r;
  assign sts.slot_full  = free_r >= slot_cnt;
  assign sts.scan_done  = scan_done;
  assign sts.sweep_last = sweep_idx_r == LAST_ADDR;
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_found_valid     = out_found_r;
  assign out_reset_count_out = out_last_r[HALF_W-1:0];
  assign out_power_count_out = out_last_r[WORD_W-1:HALF_W];
  assign out_next_slot       = out_next_r;
  assign out_page_erased     = out_erased_r;

endmodule

`default_nettype wire

/* hw/rtl/nonvolatile_counter_log_store.sv */
// Append log of 128-bit counter records (value plus complement) in an
// internal page that erases to all ones. One item at a time enters on the
// in_ channel (op, counters, raw preload words) and yields exactly one result
// item on the out_ channel: found flag, last valid counter pair, next free
// slot and an erase flag. Both channels use valid/ready.
// Steps per item, with N the slot count in use and M = MAX_RECORDS:
//   scan: up to N records, one memory read per cycle, ends early at the
//   first erased record; erase: all M records, one record cleared per cycle;
//   preload: one record write if the slot is in range; append: a read
//   and a write of the free slot, plus a scan when the free slot is
//   unknown and an erase sweep when the page is full.
// After reset the block sets every record to the erased pattern and holds
// in_ready low meanwhile; the configuration port is live throughout. A
// finished result sits in the output register; the next item
// is accepted while it waits, but its own result is held back until the
// receiver takes the earlier one. cfg_wr_en writes records_in_use at once
// and forces a rescan on the next append.
`default_nettype none

module nonvolatile_counter_log_store
  import nvcls_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [HALF_W-1:0]     in_reset_count_in,
  input  wire logic [HALF_W-1:0]     in_power_count_in,
  input  wire logic [RAW_SLOT_W-1:0] in_raw_slot,
  input  wire logic [WORD_W-1:0]     in_raw_value,
  input  wire logic [WORD_W-1:0]     in_raw_check,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_found_valid,
  output logic [HALF_W-1:0]          out_reset_count_out,
  output logic [HALF_W-1:0]          out_power_count_out,
  output logic [CFG_W-1:0]           out_next_slot,
  output logic                       out_page_erased
);

  cmd_t cmd;
  sts_t sts;

  nvcls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  nvcls_dpath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_reset_count_in   (in_reset_count_in),
    .in_power_count_in   (in_power_count_in),
    .in_raw_slot         (in_raw_slot),
    .in_raw_value        (in_raw_value),
    .in_raw_check        (in_raw_check),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_found_valid     (out_found_valid),
    .out_reset_count_out (out_reset_count_out),
    .out_power_count_out (out_power_count_out),
    .out_next_slot       (out_next_slot),
    .out_page_erased     (out_page_erased)
  );

endmodule

`default_nettype wire
